### rtl/binomial_mod_prime_assert.svh
// Assertion shorthands used by binomial_mod_prime. Each expects clk and arst_n in scope.
`ifndef BINOMIAL_MOD_PRIME_ASSERT_SVH
`define BINOMIAL_MOD_PRIME_ASSERT_SVH

// Same-cycle implication.
`define BMP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BMP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bmp_pkg.sv
package bmp_pkg;

	// Modulus and operand width.
	localparam int MW = 30;
	localparam logic [MW-1:0] PRIME = 30'd1000000007;

	// Barrett constant floor(2^61 / PRIME).
	localparam logic [31:0] BARRETT_MU = 32'd2305842993;

	// Latency of the modular multiplier in cycles.
	localparam int ML = 4;
	localparam int CW = $clog2(ML + 1);

	// Fermat exponent PRIME-2 is walked bit by bit, low bit first.
	localparam logic [MW-1:0] POW_EXP = PRIME - 30'd2;
	localparam int EXP_ROUNDS = 30;
	localparam int RW = $clog2(EXP_ROUNDS);

	localparam int TABLE_DEPTH_DEF = 4096;

	// Start-up sequencer states.
	typedef enum logic [2:0] {
		S_INIT,
		S_FACT,
		S_POW_M,
		S_POW_S,
		S_INV_TOP,
		S_INV,
		S_DONE
	} seq_state_t;

endpackage

### rtl/binomial_mod_prime.sv
// Binomial coefficient n choose k modulo 1000000007. After reset the block builds its
// factorial and inverse-factorial tables by itself, one modular multiply at a time
// through the shared multiplier, while in_ready stays low. From then on it takes one
// query per cycle while the output does not stall; each answer passes an input
// register, a table read, then two four-stage modular multiplies in series, with the
// last table read timed to meet the first product. A query with k above n, or n
// beyond the table, returns zero with invalid set. A stall on the output holds the
// whole pipeline.
`include "binomial_mod_prime_assert.svh"

module binomial_mod_prime
	import bmp_pkg::*;
	#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
	)
	(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [11:0]   top_count,
	input  logic [11:0]   pick_count,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [MW-1:0] coefficient,
	output logic          invalid
	);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int S_B = 2 + ML;
	localparam int LAST = 2 + 2 * ML;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	// Sequencer registers.
	seq_state_t    state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [MW-1:0] acc_q, acc_d;
	logic [MW-1:0] base_q, base_d;
	logic [MW-1:0] expo_q, expo_d;
	logic [RW-1:0] rnd_q, rnd_d;
	logic          busy_q, busy_d;
	logic [CW-1:0] cnt_q, cnt_d;

	logic          tables_ready;
	logic          op_done;
	logic [MW-1:0] seq_a, seq_b;
	logic          fact_we, inv_we;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;

	// Query pipeline.
	logic          advance;
	logic          v_s   [1:LAST];
	logic          bad_s [1:LAST];
	logic [AW-1:0] nk_s  [1:S_B-1];
	logic [AW-1:0] n_s1, k_s1;
	logic          bad_in;

	logic [MW-1:0] fact_rd, invk_rd, invnk_rd;
	logic [MW-1:0] mul_a_in, mul_b_in, mul_a_res, mul_b_res;
	logic          mul_a_en;

	assign tables_ready = (state_q == S_DONE);
	assign op_done = busy_q && (cnt_q == CW'(1));

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			busy_q <= busy_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		acc_q <= acc_d;
		base_q <= base_d;
		expo_q <= expo_d;
		rnd_q <= rnd_d;
	end

	// Table build: factorials upward, Fermat inverse of the top one, then inverses downward.
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		acc_d = acc_q;
		base_d = base_q;
		expo_d = expo_q;
		rnd_d = rnd_q;
		busy_d = busy_q;
		cnt_d = cnt_q;
		seq_a = acc_q;
		seq_b = MW'(idx_q);
		fact_we = 1'b0;
		inv_we = 1'b0;
		wr_addr = idx_q;
		wr_data = mul_a_res;

		if (busy_q) begin
			cnt_d = cnt_q - CW'(1);
			if (op_done) begin
				busy_d = 1'b0;
			end
		end

		case (state_q)
			S_INIT: begin
				fact_we = 1'b1;
				wr_addr = '0;
				wr_data = MW'(1);
				acc_d = MW'(1);
				idx_d = AW'(1);
				state_d = S_FACT;
			end
			S_FACT: begin
				if (!busy_q) begin
					busy_d = 1'b1;
					cnt_d = CW'(ML);
				end
				if (op_done) begin
					acc_d = mul_a_res;
					fact_we = 1'b1;
					if (idx_q == LAST_IDX) begin
						base_d = mul_a_res;
						acc_d = MW'(1);
						expo_d = POW_EXP;
						rnd_d = '0;
						state_d = S_POW_M;
					end else begin
						idx_d = idx_q + AW'(1);
					end
				end
			end
			S_POW_M: begin
				seq_b = base_q;
				if (!busy_q) begin
					busy_d = 1'b1;
					cnt_d = CW'(ML);
				end
				if (op_done) begin
					if (expo_q[0]) begin
						acc_d = mul_a_res;
					end
					state_d = S_POW_S;
				end
			end
			S_POW_S: begin
				seq_a = base_q;
				seq_b = base_q;
				if (!busy_q) begin
					busy_d = 1'b1;
					cnt_d = CW'(ML);
				end
				if (op_done) begin
					base_d = mul_a_res;
					expo_d = expo_q >> 1;
					if (rnd_q == RW'(EXP_ROUNDS - 1)) begin
						state_d = S_INV_TOP;
					end else begin
						rnd_d = rnd_q + RW'(1);
						state_d = S_POW_M;
					end
				end
			end
			S_INV_TOP: begin
				inv_we = 1'b1;
				wr_addr = LAST_IDX;
				wr_data = acc_q;
				idx_d = LAST_IDX;
				state_d = S_INV;
			end
			S_INV: begin
				wr_addr = idx_q - AW'(1);
				if (!busy_q) begin
					busy_d = 1'b1;
					cnt_d = CW'(ML);
				end
				if (op_done) begin
					acc_d = mul_a_res;
					inv_we = 1'b1;
					if (idx_q == AW'(1)) begin
						state_d = S_DONE;
					end else begin
						idx_d = idx_q - AW'(1);
					end
				end
			end
			S_DONE: begin
				state_d = S_DONE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// The whole query pipeline moves unless the result waits at the output.
	assign advance = !v_s[LAST] || out_ready;
	assign in_ready = tables_ready && advance;

	// A query is out of range when k exceeds n or n lies past the table.
	assign bad_in = (pick_count > top_count)
		|| !(32'(top_count) < 32'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= LAST; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (advance) begin
			v_s[1] <= in_valid && in_ready;
			for (int j = 2; j <= LAST; j++) begin
				v_s[j] <= v_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			n_s1 <= AW'(top_count);
			k_s1 <= AW'(pick_count);
			bad_s[1] <= bad_in;
			nk_s[1] <= AW'(top_count - pick_count);
			for (int j = 2; j <= LAST; j++) begin
				bad_s[j] <= bad_s[j-1];
			end
			for (int j = 2; j <= S_B - 1; j++) begin
				nk_s[j] <= nk_s[j-1];
			end
		end
	end

	// Factorial table.
	bmp_ram #(.W(MW), .DEPTH(TABLE_DEPTH)) u_fact (
		.clk   (clk),
		.we    (fact_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (advance),
		.raddr (n_s1),
		.rdata (fact_rd)
	);

	// Two copies of the inverse table, one read for k and one for n-k.
	bmp_ram #(.W(MW), .DEPTH(TABLE_DEPTH)) u_inv_k (
		.clk   (clk),
		.we    (inv_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (advance),
		.raddr (k_s1),
		.rdata (invk_rd)
	);

	bmp_ram #(.W(MW), .DEPTH(TABLE_DEPTH)) u_inv_nk (
		.clk   (clk),
		.we    (inv_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (advance),
		.raddr (nk_s[S_B-1]),
		.rdata (invnk_rd)
	);

	// The first multiplier serves the sequencer until the tables are built.
	assign mul_a_en = tables_ready ? advance : 1'b1;
	assign mul_a_in = tables_ready ? fact_rd : seq_a;
	assign mul_b_in = tables_ready ? invk_rd : seq_b;

	bmp_mulmod u_mul_a (
		.clk (clk),
		.en  (mul_a_en),
		.a   (mul_a_in),
		.b   (mul_b_in),
		.res (mul_a_res)
	);

	bmp_mulmod u_mul_b (
		.clk (clk),
		.en  (advance),
		.a   (mul_a_res),
		.b   (invnk_rd),
		.res (mul_b_res)
	);

	assign out_valid = v_s[LAST];
	assign invalid = bad_s[LAST];
	assign coefficient = bad_s[LAST] ? '0 : mul_b_res;

	`BMP_ASSERT_NXT(a_ready_sticky, tables_ready, tables_ready, "tables ready flag dropped")
	`BMP_ASSERT_IMP(a_no_early_query, !tables_ready, !v_s[1] && !v_s[LAST], "query during build")
	`BMP_ASSERT_NXT(a_stall_hold, v_s[LAST] && !out_ready, v_s[LAST] && $stable(bad_s[LAST]), "result lost in stall")

endmodule

### rtl/bmp_ram.sv
module bmp_ram
	#(
	parameter int W = 30,
	parameter int DEPTH = 4096
	)
	(
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
	);

	logic [W-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/bmp_mulmod.sv
module bmp_mulmod
	import bmp_pkg::*;
	(
	input  logic          clk,
	input  logic          en,
	input  logic [MW-1:0] a,
	input  logic [MW-1:0] b,
	output logic [MW-1:0] res
	);

	logic [2*MW-1:0] prod_s1;
	logic [62:0]     tm_s2;
	logic [31:0]     x_s2;
	logic [31:0]     qp_s3;
	logic [31:0]     x_s3;
	logic [MW-1:0]   res_s4;
	logic [31:0]     r;
	logic [31:0]     p1;
	logic [31:0]     p2;

	// Final correction: the Barrett estimate leaves a remainder below three times the prime.
	always_comb begin
		r = x_s3 - qp_s3;
		p1 = 32'(PRIME);
		p2 = 32'(PRIME) << 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Full product.
			prod_s1 <= (2*MW)'(a) * (2*MW)'(b);
			// Quotient estimate from the top bits of the product.
			tm_s2 <= 63'(prod_s1[2*MW-1:29]) * 63'(BARRETT_MU);
			x_s2 <= prod_s1[31:0];
			// Quotient times prime; only the low word matters for the remainder.
			qp_s3 <= 32'(tm_s2[62:32]) * 32'(PRIME);
			x_s3 <= x_s2;
			if (r >= p2) begin
				res_s4 <= MW'(r - p2);
			end else if (r >= p1) begin
				res_s4 <= MW'(r - p1);
			end else begin
				res_s4 <= MW'(r);
			end
		end
	end

	assign res = res_s4;

endmodule

### tb/tb_binomial_mod_prime.sv
module tb_binomial_mod_prime;
	import bmp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 4096;
	localparam int RANDOM_ITEMS = 480;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	// Nothing is accepted during the table build after reset; the limit must cover it.
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [MW-1:0] coefficient;
		logic          invalid;
	} answer_t;

	typedef struct {
		logic [11:0]   n;
		logic [11:0]   k;
		bit            typed;
		logic [MW-1:0] coefficient;
		logic          invalid;
	} query_row_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [11:0]   top_count;
	logic [11:0]   pick_count;
	logic          out_valid;
	logic          out_ready;
	logic [MW-1:0] coefficient;
	logic          invalid;

	logic [MW-1:0] fact_mod [DEPTH];
	logic [MW-1:0] inv_fact_mod [DEPTH];
	answer_t       pending_answers [$];
	int            send_idle_pct;
	int            recv_idle_pct;
	bit            hold_request;
	int            quiet_cycles;
	int            fail_count;

	binomial_mod_prime dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.top_count  (top_count),
		.pick_count (pick_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coefficient(coefficient),
		.invalid    (invalid)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [MW-1:0] mul_prime(logic [MW-1:0] a, logic [MW-1:0] b);
		longint unsigned prod;
		prod = longint'(a) * longint'(b);
		return MW'(prod % longint'(PRIME));
	endfunction

	function automatic logic [MW-1:0] pow_prime(logic [MW-1:0] base, logic [MW-1:0] expo);
		logic [MW-1:0] acc;
		acc = 1;
		while (expo != 0) begin
			if (expo[0])
				acc = mul_prime(acc, base);
			base = mul_prime(base, base);
			expo = expo >> 1;
		end
		return acc;
	endfunction

	// Build the factorial and inverse-factorial tables the same way the block does.
	task automatic build_tables();
		fact_mod[0] = 1;
		for (int i = 1; i < DEPTH; i++)
			fact_mod[i] = mul_prime(fact_mod[i-1], MW'(i));
		inv_fact_mod[DEPTH-1] = pow_prime(fact_mod[DEPTH-1], PRIME - 30'd2);
		for (int i = DEPTH - 1; i > 0; i--)
			inv_fact_mod[i-1] = mul_prime(inv_fact_mod[i], MW'(i));
	endtask

	function automatic answer_t choose_mod(logic [11:0] n, logic [11:0] k);
		answer_t a;
		a.coefficient = 0;
		a.invalid = 1'b1;
		if (k <= n && n < DEPTH) begin
			a.coefficient = mul_prime(mul_prime(fact_mod[n], inv_fact_mod[k]),
				inv_fact_mod[n-k]);
			a.invalid = 1'b0;
		end
		return a;
	endfunction

	// Offer one request and hold it until it is accepted.
	task automatic send_query(logic [11:0] n, logic [11:0] k, answer_t want);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		top_count <= n;
		pick_count <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_answers.push_back(want);
		@(negedge clk);
	endtask

	task automatic random_queries(int count);
		logic [11:0] n;
		logic [11:0] k;
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(99);
			n = 12'($urandom);
			k = 12'($urandom);
			if (mode < 55) begin
				// Well-formed request with k at or below n.
				k = (n == 0) ? 12'd0 : 12'($urandom_range(n));
			end else if (mode < 65) begin
				n = 12'($urandom_range(20));
				k = 12'($urandom_range(n));
			end else if (mode < 75) begin
				n = $urandom_range(1) ? 12'd4095 : 12'($urandom_range(4090, 4095));
				k = $urandom_range(1) ? n : 12'($urandom_range(n));
			end else if (mode < 85) begin
				// k above n.
				if (n == 12'd4095)
					n = 12'd4094;
				k = 12'($urandom_range(n + 1, 4095));
			end
			send_query(n, k, choose_mod(n, k));
		end
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
				@(negedge clk);
			end
		end
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				$error("result with no request outstanding: coefficient %0d invalid %0d",
					coefficient, invalid);
				fail_count++;
			end else begin
				want = pending_answers.pop_front();
				if (coefficient !== want.coefficient) begin
					$error("coefficient: expected %0d, actual %0d", want.coefficient, coefficient);
					fail_count++;
				end
				if (invalid !== want.invalid) begin
					$error("invalid: expected %0d, actual %0d", want.invalid, invalid);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		query_row_t rows [$];
		answer_t    want;

		arst_n = 1'b0;
		in_valid = 1'b0;
		top_count = '0;
		pick_count = '0;
		hold_request = 1'b0;
		quiet_cycles = 0;
		fail_count = 0;
		send_idle_pct = 15;
		recv_idle_pct = 77;
		build_tables();

		// Directed requests: extremes, small cases and invalid cases carry typed answers.
		rows = '{
			'{12'd0,    12'd0,    1, 30'd1,    1'b0},
			'{12'd1,    12'd0,    1, 30'd1,    1'b0},
			'{12'd1,    12'd1,    1, 30'd1,    1'b0},
			'{12'd4095, 12'd0,    1, 30'd1,    1'b0},
			'{12'd4095, 12'd4095, 1, 30'd1,    1'b0},
			'{12'd4095, 12'd1,    1, 30'd4095, 1'b0},
			'{12'd4095, 12'd4094, 1, 30'd4095, 1'b0},
			'{12'd5,    12'd2,    1, 30'd10,   1'b0},
			'{12'd10,   12'd3,    1, 30'd120,  1'b0},
			'{12'd0,    12'd4095, 1, 30'd0,    1'b1},
			'{12'd0,    12'd1,    1, 30'd0,    1'b1},
			'{12'd4094, 12'd4095, 1, 30'd0,    1'b1},
			'{12'd1,    12'd2,    1, 30'd0,    1'b1},
			'{12'h555,  12'hAAA,  1, 30'd0,    1'b1},
			'{12'hAAA,  12'h555,  0, 30'd0,    1'b0},
			'{12'd2048, 12'd1024, 0, 30'd0,    1'b0},
			'{12'd4095, 12'd2047, 0, 30'd0,    1'b0},
			'{12'd4095, 12'd2048, 0, 30'd0,    1'b0},
			'{12'd100,  12'd50,   0, 30'd0,    1'b0},
			'{12'd3000, 12'd7,    0, 30'd0,    1'b0}
		};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				want.coefficient = rows[i].coefficient;
				want.invalid = rows[i].invalid;
			end else begin
				want = choose_mod(rows[i].n, rows[i].k);
			end
			send_query(rows[i].n, rows[i].k, want);
		end

		random_queries(RANDOM_ITEMS / 3);
		send_idle_pct = 77;
		recv_idle_pct = 15;
		random_queries(RANDOM_ITEMS / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Stall the output long enough for the pipeline to fill and block input.
		hold_request = 1'b1;
		random_queries(RANDOM_ITEMS / 3);
		in_valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
